// File: src/lph_pkg.sv
// Shared types and codes of the linear probing hash table.
package lph_pkg;

  localparam int unsigned TABLE_SLOTS = 31;
  localparam int unsigned KEY_BITS    = 31;

  localparam int unsigned KEY_W  = KEY_BITS;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);

  // Key bits folded into the home slot remainder in one cycle.
  localparam int unsigned DIGIT_BITS = 8;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
  } lph_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  found_value;
    logic [SLOT_W-1:0] slot;
  } lph_rsp_t;

endpackage

// File: src/lph_mod_unit.sv
// Iterative reduction of a key modulo the slot count, one digit per cycle.
module lph_mod_unit #(
  parameter int unsigned TABLE_SLOTS = 31,
  parameter int unsigned KEY_BITS    = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [KEY_BITS-1:0]            key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] rem_o
);
  import lph_pkg::*;

  localparam int unsigned IW    = $clog2(TABLE_SLOTS);
  localparam int unsigned NDIG  = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PW    = NDIG * DIGIT_BITS;
  localparam int unsigned CW    = $clog2(NDIG + 1);
  localparam logic [IW:0] MODN  = (IW+1)'(TABLE_SLOTS);

  logic [PW-1:0] sh_q, sh_d;
  logic [IW:0]   r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [IW:0]   r_step;

  // Restoring reduction: the remainder stays below the slot count, so one
  // conditional subtract after each shifted-in bit keeps it reduced.
  always_comb begin
    r_step = r_q;
    for (int i = 0; i < int'(DIGIT_BITS); i++) begin
      r_step = {r_step[IW-1:0], sh_q[PW-1-i]};
      if (r_step >= MODN) begin
        r_step = r_step - MODN;
      end
    end
  end

  always_comb begin
    sh_d   = sh_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (load_i) begin
      sh_d  = PW'(key_i);
      r_d   = '0;
      cnt_d = CW'(NDIG);
    end else if (cnt_q != '0) begin
      sh_d  = sh_q << DIGIT_BITS;
      r_d   = r_step;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      r_q    <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      sh_q   <= sh_d;
      r_q    <= r_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q[IW-1:0];

endmodule

// File: src/lph_slot_ram.sv
// Slot store: one write port and one read port with registered read data.
module lph_slot_ram #(
  parameter int unsigned DEPTH = 31,
  parameter int unsigned WIDTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/linear_probe_hash_table.sv
// Linear probing hash table: top level with the probe sequencer.
// After reset a clearing pass writes zero to every slot and empties the store; busy is high meanwhile.
// A rejected word (zero key, unused mode, insert into a full table) answers in the cycle after it is taken.
// Otherwise the modulo unit folds the key into the home slot a digit at a time, and the
// sequencer then probes the slots in order from there through the single read port.
// One word at a time: the next word can be taken at the edge that takes the result,
// the result strobe lasts one cycle and the receiver cannot stall.
module linear_probe_hash_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lph_pkg::lph_req_t req_i,
  output logic              rsp_valid_o,
  output lph_pkg::lph_rsp_t rsp_o
);
  import lph_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned NW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CHECK
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     probe_q, probe_d;
  logic [NW-1:0]     count_q, count_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic              rsp_valid_q, rsp_valid_d;
  lph_rsp_t          rsp_q, rsp_d;

  logic [KEY_BITS-1:0] key_in;
  logic                accept;
  logic                mod_done;
  logic [AW-1:0]       mod_rem;
  logic [AW-1:0]       next_idx;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [KEY_BITS-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [KEY_BITS-1:0] cur;

  assign key_in   = KEY_BITS'(req_i.key);
  assign accept   = start && (state_q == S_IDLE);
  assign next_idx = (idx_q == AW'(TABLE_SLOTS - 1)) ? '0 : idx_q + AW'(1);

  lph_mod_unit #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .KEY_BITS   (KEY_BITS)
  ) u_mod (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(accept),
    .key_i (key_in),
    .done_o(mod_done),
    .rem_o (mod_rem)
  );

  lph_slot_ram #(
    .DEPTH(TABLE_SLOTS),
    .WIDTH(KEY_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(cur)
  );

  // The next slot is read speculatively while the current one is checked.
  assign ram_raddr = (state_q == S_HASH) ? mod_rem : next_idx;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    probe_d     = probe_q;
    count_d     = count_q;
    mode_d      = mode_q;
    key_d       = key_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        idx_d  = next_idx;
        if (idx_q == AW'(TABLE_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d = req_i.mode;
          key_d  = key_in;
          if (key_in == '0 || (req_i.mode != MODE_INSERT && req_i.mode != MODE_DELETE &&
                               req_i.mode != MODE_SEARCH)) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: STATUS_MISS, found_value: '0, slot: '0};
          end else if (req_i.mode == MODE_INSERT && count_q == NW'(TABLE_SLOTS)) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{status: STATUS_FULL, found_value: '0, slot: '0};
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          idx_d   = mod_rem;
          probe_d = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mode_q == MODE_INSERT && cur == '0) begin
          ram_we      = 1'b1;
          ram_wdata   = key_q;
          count_d     = count_q + NW'(1);
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: STATUS_OK, found_value: '0, slot: SLOT_W'(idx_q)};
          state_d     = S_IDLE;
        end else if (mode_q != MODE_INSERT && cur == '0) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: STATUS_MISS, found_value: '0, slot: '0};
          state_d     = S_IDLE;
        end else if (mode_q != MODE_INSERT && cur == key_q) begin
          if (mode_q == MODE_DELETE) begin
            ram_we = 1'b1;
            if (count_q != '0) begin
              count_d = count_q - NW'(1);
            end
          end
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: STATUS_OK, found_value: KEY_W'(key_q),
                          slot: SLOT_W'(idx_q)};
          state_d     = S_IDLE;
        end else if (probe_q == AW'(TABLE_SLOTS - 1)) begin
          // A whole pass without an empty slot or the key.
          rsp_valid_d = 1'b1;
          rsp_d       = '{status: (mode_q == MODE_INSERT) ? STATUS_FULL : STATUS_MISS,
                          found_value: '0, slot: '0};
          state_d     = S_IDLE;
        end else begin
          idx_d   = next_idx;
          probe_d = probe_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      probe_q     <= '0;
      count_q     <= '0;
      mode_q      <= '0;
      key_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      probe_q     <= probe_d;
      count_q     <= count_d;
      mode_q      <= mode_d;
      key_q       <= key_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
